// File: sv/mtwt_pkg.sv
// ============================================================================
// mtwt_pkg
// Shared types, constants and helpers of the markup text word tokenizer.
// ============================================================================
package mtwt_pkg;

  // Word store geometry
  localparam int STORE_DEPTH  = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  // Run length saturates at STORE_DEPTH + 1
  localparam int LEN_W        = $clog2(STORE_DEPTH + 2);

  // Configuration registers
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WORD_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD_LEN = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     MIN_LEN_RST      = CFG_W'(3);
  localparam logic [CFG_W-1:0]     MAX_LEN_RST      = CFG_W'(36);

  // Compare width covers both the run length and the register values
  localparam int CMP_W    = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int MAX_EMIT = (STORE_DEPTH < RESULT_LIMIT) ? STORE_DEPTH : RESULT_LIMIT;

  // Character codes
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] letter;
    logic       word_done;
  } out_word_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
  endfunction

endpackage

// File: sv/mtwt_ram.sv
// ============================================================================
// mtwt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module mtwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/markup_text_word_tokenizer.sv
// ============================================================================
// markup_text_word_tokenizer
// Splits markup text into words of letters found outside tags and emits each
// accepted word from a word store, one letter per word on the output channel.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | in_word_t  {data_byte, eot}
//  out_    | output    | out_valid/out_stall| out_word_t {letter, word_done}
//  cfg_    | input     | cfg_we             | cfg_idx, cfg_wdata
//
//  A byte that does not close an accepted word is taken without a stall. A
//  byte that closes an accepted word stalls the input while its letters are
//  read back out of the word store, one read in flight at a time through
//  the registered read port, and longer while the output stalls meanwhile.
//  Reset (synchronous, rst_n low) clears the tag mark, the run length, the
//  output register and the registers to their defaults; the word store is
//  not cleared since only entries written for the current word are read.
//  Output stalls hold the output register; the next byte is accepted while
//  the last letter of a word still waits there.
//
module markup_text_word_tokenizer (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mtwt_pkg::in_word_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output mtwt_pkg::out_word_t                 out_data,
  // configuration port
  input  logic                                cfg_we,
  input  logic [mtwt_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mtwt_pkg::CFG_W-1:0]          cfg_wdata
);

  import mtwt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // Control state
  logic              state_r,     state_nxt;
  logic              in_markup_r, in_markup_nxt;
  logic [LEN_W-1:0]  run_len_r,   run_len_nxt;
  logic [ADDR_W-1:0] rd_idx_r,    rd_idx_nxt;
  logic [ADDR_W-1:0] last_idx_r,  last_idx_nxt;
  logic              pend_r,      pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]  min_len_r;
  logic [CFG_W-1:0]  max_len_r;

  // Payload
  out_word_t         out_data_r,  out_data_nxt;

  // Datapath
  logic              in_fire;
  logic              letter_path;
  logic              close_word;
  logic              emit_ok;
  logic [LEN_W-1:0]  new_len;
  logic [LEN_W-1:0]  len_m1;
  logic [CMP_W-1:0]  len_c, min_c, hi_c, max_c;
  logic              rd_issue;
  logic              wr_en;
  logic [7:0]        rd_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Word tracking: letters outside tags grow the run; anything else closes it
  assign letter_path = !in_markup_r && is_letter(in_data.data_byte);
  assign wr_en       = in_fire && letter_path && (run_len_r < LEN_W'(STORE_DEPTH));

  always_comb begin
    new_len = run_len_r;
    if (letter_path && (run_len_r <= LEN_W'(STORE_DEPTH))) begin
      new_len = run_len_r + LEN_W'(1);
    end
  end

  assign close_word = letter_path ? in_data.end_of_text : (run_len_r != '0);

  // Length filter: effective maximum is capped by store depth and result limit
  assign len_c = CMP_W'(new_len);
  assign min_c = CMP_W'(min_len_r);
  assign max_c = CMP_W'(max_len_r);
  assign hi_c  = (max_c > CMP_W'(MAX_EMIT)) ? CMP_W'(MAX_EMIT) : max_c;
  assign emit_ok = close_word && (new_len != '0) && (len_c >= min_c) && (len_c <= hi_c);
  assign len_m1  = new_len - LEN_W'(1);

  // Read issue: one read in flight, and only when the output slot frees up
  assign rd_issue = (state_r == ST_EMIT) && !pend_r && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    in_markup_nxt = in_markup_r;
    run_len_nxt   = run_len_r;
    rd_idx_nxt    = rd_idx_r;
    last_idx_nxt  = last_idx_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          run_len_nxt = (close_word || in_data.end_of_text) ? '0 : new_len;
          if (in_data.data_byte == CH_GT) begin
            in_markup_nxt = 1'b0;
          end
          if (in_data.data_byte == CH_LT) begin
            in_markup_nxt = 1'b1;
          end
          if (in_data.end_of_text) begin
            in_markup_nxt = 1'b0;
          end
          if (emit_ok) begin
            state_nxt    = ST_EMIT;
            rd_idx_nxt   = '0;
            last_idx_nxt = len_m1[ADDR_W-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (rd_issue) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = (rd_idx_r == last_idx_r);
          if (rd_idx_r == last_idx_r) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register: drain on take, load from the returning read
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.letter    = rd_data;
      out_data_nxt.word_done = pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_markup_r <= 1'b0;
      run_len_r   <= '0;
      rd_idx_r    <= '0;
      last_idx_r  <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_markup_r <= in_markup_nxt;
      run_len_r   <= run_len_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_idx_r  <= last_idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_WORD_LEN: min_len_r <= cfg_wdata;
        REG_MAX_WORD_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Word store: write letters as they arrive, read them back for emission
  mtwt_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_word_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (run_len_r[ADDR_W-1:0]),
    .wdata (in_data.data_byte),
    .re    (rd_issue),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

endmodule

// File: sv/mtwt_checker.sv
// ============================================================================
// mtwt_checker
// Port-level checks of the markup text word tokenizer.
// ============================================================================
module mtwt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input mtwt_pkg::out_word_t            out_data
);

  import mtwt_pkg::*;

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Only letters leave the block
  a_letter_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_letter(out_data.letter))
    else $error("non-letter on output");

  // Mid-word: input stays held until the word is fully issued
  a_mid_word_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.word_done) |-> in_stall)
    else $error("input taken in the middle of a word");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output changed");

endmodule

bind markup_text_word_tokenizer mtwt_checker u_mtwt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
